[sv/script_hash_pattern_scanner_defines.svh]
// Assertion macros for the script hash pattern scanner.
// Used by the top level only; no other dependencies.
`ifndef SCRIPT_HASH_PATTERN_SCANNER_DEFINES_SVH
`define SCRIPT_HASH_PATTERN_SCANNER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define SHS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("shs: same-cycle check failed");
// Next-cycle implication.
`define SHS_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("shs: next-cycle check failed");
`else
`define SHS_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define SHS_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

[sv/shs_pkg.sv]
// Types and constants for the script hash pattern scanner.
// No dependencies.
`timescale 1ns / 1ps
package shs_pkg;
	localparam int WIN_LEN         = 25;
	localparam int HASH_LEN        = 20;
	localparam int HASH_ENTRIES    = 64;
	localparam int ENTRY_BITS      = 6;
	localparam int WORDS_PER_ENTRY = 5;
	localparam int OFFSET_BITS     = 32;
	localparam int FILL_BITS       = 5;

	localparam logic [7:0] B_DUP     = 8'h76;
	localparam logic [7:0] B_HASH160 = 8'ha9;
	localparam logic [7:0] B_PUSH20  = 8'h14;
	localparam logic [7:0] B_EQVFY   = 8'h88;
	localparam logic [7:0] B_CHKSIG  = 8'hac;
	localparam logic [7:0] B_EQUAL   = 8'h87;

	typedef enum logic [1:0] {
		OP_SCAN  = 2'd0,
		OP_WRITE = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NEW   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_PKH  = 2'd1,
		KIND_SH   = 2'd2
	} kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;
endpackage

[sv/script_hash_pattern_scanner.sv]
// Script hash pattern scanner: 25-byte window, pattern detect, hash set lookup.
// Depends on shs_pkg and script_hash_pattern_scanner_defines.svh.
//
//  channel  | handshake            | payload
//  input    | in_valid / in_ready  | op, byte_value, last_byte, entry_index, word_index, hash_word
//  output   | out_valid / out_ready| hit, hit_kind, hit_offset, file_match, file_done
//
// Non-candidate bytes and set operations write their result straight to the output register.
// A byte whose window matches a script pattern walks the hash set, one entry
// per cycle through the five-bank hash memory, until a hit or the last entry.
// Reset clears window fill, offset, match flag and all entry valid bits.
// Input is held off while a lookup runs or the output register is full and stalled.
`timescale 1ns / 1ps
`include "script_hash_pattern_scanner_defines.svh"
module script_hash_pattern_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	input  logic [5:0]  entry_index,
	input  logic [2:0]  word_index,
	input  logic [31:0] hash_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [1:0]  hit_kind,
	output logic [31:0] hit_offset,
	output logic        file_match,
	output logic        file_done
);
	localparam int HB = shs_pkg::HASH_LEN * 8;
	localparam int OB = shs_pkg::OFFSET_BITS;
	localparam int EB = shs_pkg::ENTRY_BITS;

	shs_pkg::state_t state_q, state_d;

	logic [7:0]   win_q [shs_pkg::WIN_LEN];
	logic [7:0]   nwin  [shs_pkg::WIN_LEN];
	logic [shs_pkg::FILL_BITS-1:0] fill_q, fill_d;
	logic [OB-1:0] off_q;
	logic         match_q;
	logic [shs_pkg::HASH_ENTRIES-1:0] valid_q;

	logic [31:0]  hash_mem [shs_pkg::WORDS_PER_ENTRY][shs_pkg::HASH_ENTRIES];
	logic [31:0]  rd_s1    [shs_pkg::WORDS_PER_ENTRY];
	logic         rd_s1_v;
	logic [EB-1:0] ent_s1;
	logic [EB-1:0] addr_q;
	logic         iss_done_q;

	shs_pkg::kind_t kind_q;
	logic [OB-1:0] cand_off_q;
	logic         last_q;

	logic         accept, issue, found, finish, cand;
	shs_pkg::kind_t new_kind;
	logic [HB-1:0] cand_hash, rd_hash;
	shs_pkg::op_t op_in;

	logic         hit_q, done_q, fmatch_q, ovalid_q;
	logic [1:0]   hkind_q;
	logic [31:0]  hoff_q;

	assign op_in    = shs_pkg::op_t'(op);
	assign in_ready = (state_q == shs_pkg::ST_IDLE) && (!ovalid_q || out_ready);
	assign accept   = in_valid && in_ready;

	// Window after shifting in the incoming byte.
	always_comb begin
		for (int i = 0; i < shs_pkg::WIN_LEN - 1; i++) begin
			nwin[i] = win_q[i+1];
		end
		nwin[shs_pkg::WIN_LEN-1] = byte_value;
	end

	assign fill_d = (fill_q == shs_pkg::FILL_BITS'(shs_pkg::WIN_LEN)) ? fill_q :
		fill_q + 1'b1;

	always_comb begin
		new_kind = shs_pkg::KIND_NONE;
		if (nwin[0] == shs_pkg::B_DUP && nwin[1] == shs_pkg::B_HASH160 &&
			nwin[2] == shs_pkg::B_PUSH20 && nwin[23] == shs_pkg::B_EQVFY &&
			nwin[24] == shs_pkg::B_CHKSIG) begin
			new_kind = shs_pkg::KIND_PKH;
		end else if (nwin[0] == shs_pkg::B_HASH160 && nwin[1] == shs_pkg::B_PUSH20 &&
			nwin[22] == shs_pkg::B_EQUAL) begin
			new_kind = shs_pkg::KIND_SH;
		end
	end
	assign cand = (fill_d == shs_pkg::FILL_BITS'(shs_pkg::WIN_LEN)) &&
		(new_kind != shs_pkg::KIND_NONE);

	// Candidate hash from the held window; byte k sits at bits 8k+7:8k.
	always_comb begin
		for (int k = 0; k < shs_pkg::HASH_LEN; k++) begin
			cand_hash[8*k +: 8] = (kind_q == shs_pkg::KIND_PKH) ? win_q[3+k] : win_q[2+k];
		end
		for (int w = 0; w < shs_pkg::WORDS_PER_ENTRY; w++) begin
			rd_hash[32*w +: 32] = rd_s1[w];
		end
	end

	assign found  = rd_s1_v && valid_q[ent_s1] && (rd_hash == cand_hash);
	assign finish = (state_q == shs_pkg::ST_SEARCH) &&
		(found || (rd_s1_v && ent_s1 == EB'(shs_pkg::HASH_ENTRIES - 1)));
	assign issue  = (state_q == shs_pkg::ST_SEARCH) && !iss_done_q && !finish;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			shs_pkg::ST_IDLE: begin
				if (accept && op_in == shs_pkg::OP_SCAN && cand) begin
					state_d = shs_pkg::ST_SEARCH;
				end
			end
			shs_pkg::ST_SEARCH: begin
				if (finish) begin
					state_d = shs_pkg::ST_IDLE;
				end
			end
			default: state_d = shs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hash memory: five word banks, one entry read per cycle.
	always_ff @(posedge clk) begin
		for (int k = 0; k < shs_pkg::WORDS_PER_ENTRY; k++) begin
			if (accept && op_in == shs_pkg::OP_WRITE && word_index == 3'(k)) begin
				hash_mem[k][entry_index] <= hash_word;
			end
			rd_s1[k] <= hash_mem[k][addr_q];
		end
		ent_s1 <= addr_q;
	end

	always_ff @(posedge clk) begin
		if (accept && op_in == shs_pkg::OP_SCAN) begin
			for (int i = 0; i < shs_pkg::WIN_LEN; i++) begin
				win_q[i] <= nwin[i];
			end
			kind_q     <= new_kind;
			cand_off_q <= off_q - OB'(shs_pkg::WIN_LEN - 1);
			last_q     <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			off_q      <= '0;
			match_q    <= 1'b0;
			valid_q    <= '0;
			addr_q     <= '0;
			iss_done_q <= 1'b0;
			rd_s1_v    <= 1'b0;
			ovalid_q   <= 1'b0;
			hit_q      <= 1'b0;
			hkind_q    <= '0;
			hoff_q     <= '0;
			fmatch_q   <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			rd_s1_v <= issue;
			if (issue) begin
				addr_q     <= addr_q + 1'b1;
				iss_done_q <= (addr_q == EB'(shs_pkg::HASH_ENTRIES - 1));
			end
			// A candidate byte holds its result back until the lookup ends.
			ovalid_q <= finish ||
				(accept && !(op_in == shs_pkg::OP_SCAN && cand)) ||
				(ovalid_q && !out_ready);
			if (accept) begin
				addr_q     <= '0;
				iss_done_q <= 1'b0;
				hit_q      <= 1'b0;
				hkind_q    <= shs_pkg::KIND_NONE;
				hoff_q     <= '0;
				done_q     <= (op_in == shs_pkg::OP_SCAN) && !cand && last_byte;
				fmatch_q   <= (op_in == shs_pkg::OP_NEW) ? 1'b0 : match_q;
				unique case (op_in)
					shs_pkg::OP_SCAN: begin
						if (cand) begin
							fill_q   <= fill_d;
							off_q    <= off_q + 1'b1;
						end else begin
							if (last_byte) begin
								fill_q  <= '0;
								off_q   <= '0;
								match_q <= 1'b0;
							end else begin
								fill_q <= fill_d;
								off_q  <= off_q + 1'b1;
							end
						end
					end
					shs_pkg::OP_WRITE: begin
						if (word_index == 3'(shs_pkg::WORDS_PER_ENTRY - 1)) begin
							valid_q[entry_index] <= 1'b1;
						end
					end
					shs_pkg::OP_CLEAR: begin
						valid_q <= '0;
					end
					shs_pkg::OP_NEW: begin
						fill_q   <= '0;
						off_q    <= '0;
						match_q  <= 1'b0;
					end
					default: ;
				endcase
			end
			if (finish) begin
				hit_q    <= found;
				hkind_q  <= found ? kind_q : shs_pkg::KIND_NONE;
				hoff_q   <= found ? cand_off_q[31:0] : 32'd0;
				fmatch_q <= match_q || found;
				done_q   <= last_q;
				if (last_q) begin
					fill_q  <= '0;
					off_q   <= '0;
					match_q <= 1'b0;
				end else begin
					match_q <= match_q || found;
				end
			end
		end
	end

	assign out_valid  = ovalid_q;
	assign hit        = hit_q;
	assign hit_kind   = hkind_q;
	assign hit_offset = hoff_q;
	assign file_match = fmatch_q;
	assign file_done  = done_q;

	`SHS_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q == shs_pkg::ST_SEARCH, !in_ready)
	`SHS_ASSERT_IMP(a_hit_kind, clk, arst_n, out_valid && hit, hit_kind != shs_pkg::KIND_NONE && file_match)
	`SHS_ASSERT_IMP(a_miss_zero, clk, arst_n, out_valid && !hit, hit_offset == 32'd0 && hit_kind == shs_pkg::KIND_NONE)
	`SHS_ASSERT_NXT(a_search_starts_empty, clk, arst_n, accept, !rd_s1_v)
endmodule
